// File: sv/glpw_pkg.sv
// Shared types and constants for the gauge loop product walker.
// Used by every module of the block but glpw_ram; depends on nothing.
`default_nettype none
package glpw_pkg;

	localparam int MAX_SITES      = 4096;
	localparam int MAX_DIMS       = 4;
	localparam int GROUP_ELEMENTS = 256;
	localparam int MAX_EXTENT     = 64;

	localparam int SITE_W   = $clog2(MAX_SITES);
	localparam int DIR_W    = $clog2(MAX_DIMS);
	localparam int ELEM_W   = $clog2(GROUP_ELEMENTS);
	localparam int COORD_W  = $clog2(MAX_EXTENT);
	localparam int EXT_W    = COORD_W + 1;
	// Linear position over the full periodic volume, up to MAX_EXTENT^MAX_DIMS.
	localparam int STRIDE_W = COORD_W * MAX_DIMS + 1;
	localparam int LINK_AW  = SITE_W + DIR_W;
	localparam int PROD_AW  = 2 * ELEM_W;
	localparam int LEN_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 8;
	localparam int IN_W     = 56;

	typedef enum logic [2:0] {
		F_WR_LINK = 3'd0,
		F_WR_PROD = 3'd1,
		F_WR_INV  = 3'd2,
		F_WILSON  = 3'd3,
		F_POLY    = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		R_NUM_DIMS    = 3'd0,
		R_TIME_EXT    = 3'd1,
		R_SPACE_EXT   = 3'd2,
		R_IDENTITY    = 3'd3
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_START,
		S_DIV_WAIT,
		S_SEG,
		S_ADV,
		S_LINK,
		S_INV,
		S_MUL,
		S_UPD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]                            dims;
		logic [EXT_W-1:0]                      ext_time;
		logic [EXT_W-1:0]                      ext_space;
		logic [ELEM_W-1:0]                     identity;
		logic [MAX_DIMS:0][STRIDE_W-1:0]       stride;
		logic                                  settled;
	} geom_t;

endpackage
`default_nettype wire

// File: sv/glpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none
module glpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/glpw_div.sv
// Radix-2 restoring divider used to split a site index into coordinates.
// Depends on glpw_pkg for widths.
`default_nettype none
module glpw_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [glpw_pkg::SITE_W-1:0] dividend,
	input  wire logic [glpw_pkg::EXT_W-1:0]  divisor,
	output logic                            done,
	output logic      [glpw_pkg::SITE_W-1:0] quotient,
	output logic      [glpw_pkg::COORD_W-1:0] remainder
);
	import glpw_pkg::*;

	localparam int CNT_W = $clog2(SITE_W + 1);

	logic [EXT_W-1:0]  rem_q;
	logic [SITE_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [EXT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[SITE_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(SITE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? EXT_W'(trial - {1'b0, divisor}) : EXT_W'(trial);
			quo_q <= {quo_q[SITE_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[COORD_W-1:0];
endmodule
`default_nettype wire

// File: sv/glpw_geom.sv
// Configuration registers and lattice geometry: clamped extents and strides.
// Depends on glpw_pkg for geom_t and register codes.
`default_nettype none
module glpw_geom (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [glpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [glpw_pkg::CFG_W-1:0]     cfg_data,
	output glpw_pkg::geom_t                     geom
);
	import glpw_pkg::*;

	logic [2:0]        num_dims_q;
	logic [6:0]        time_ext_q;
	logic [6:0]        space_ext_q;
	logic [ELEM_W-1:0] identity_q;
	logic [2:0]        settle_q;
	logic [MAX_DIMS:1][STRIDE_W-1:0] stride_q;
	logic [2:0]        dims_c;
	logic [EXT_W-1:0]  ext_t_c;
	logic [EXT_W-1:0]  ext_s_c;

	always_comb begin
		if (num_dims_q < 3'd2) begin
			dims_c = 3'd2;
		end else if (num_dims_q > 3'(MAX_DIMS)) begin
			dims_c = 3'(MAX_DIMS);
		end else begin
			dims_c = num_dims_q;
		end
		if (time_ext_q == '0) begin
			ext_t_c = EXT_W'(1);
		end else if (time_ext_q > 7'(MAX_EXTENT)) begin
			ext_t_c = EXT_W'(MAX_EXTENT);
		end else begin
			ext_t_c = EXT_W'(time_ext_q);
		end
		if (space_ext_q == '0) begin
			ext_s_c = EXT_W'(1);
		end else if (space_ext_q > 7'(MAX_EXTENT)) begin
			ext_s_c = EXT_W'(MAX_EXTENT);
		end else begin
			ext_s_c = EXT_W'(space_ext_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q  <= 3'd4;
			time_ext_q  <= 7'd8;
			space_ext_q <= 7'd8;
			identity_q  <= '0;
			settle_q    <= 3'(MAX_DIMS);
		end else begin
			if (cfg_we) begin
				settle_q <= 3'(MAX_DIMS);
				case (reg_t'(cfg_index))
					R_NUM_DIMS:  num_dims_q  <= cfg_data[2:0];
					R_TIME_EXT:  time_ext_q  <= cfg_data[6:0];
					R_SPACE_EXT: space_ext_q <= cfg_data[6:0];
					R_IDENTITY:  identity_q  <= cfg_data[ELEM_W-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	// One multiplication per register after the first, which takes the time extent.
	always_ff @(posedge clk) begin
		stride_q[1] <= STRIDE_W'(ext_t_c);
		for (int k = 2; k <= MAX_DIMS; k++) begin
			stride_q[k] <= STRIDE_W'(stride_q[k-1] * ext_s_c);
		end
	end

	always_comb begin
		geom.dims      = dims_c;
		geom.ext_time  = ext_t_c;
		geom.ext_space = ext_s_c;
		geom.identity  = identity_q;
		geom.stride[0] = STRIDE_W'(1);
		for (int k = 1; k <= MAX_DIMS; k++) begin
			geom.stride[k] = stride_q[k];
		end
		geom.settled   = settle_q == '0;
	end
endmodule
`default_nettype wire

// File: sv/gauge_loop_product_walker_unit.sv
// Top level of the gauge loop product walker: request sequencer and stores.
// Depends on glpw_pkg, glpw_geom, glpw_div and glpw_ram.
`default_nettype none
// The unit holds a periodic lattice gauge field (one 8-bit group element per
// link), a group multiplication table and an inverse table, each in its own
// RAM with registered read. A store write (func 0, 1, 2) is taken in the idle
// state and returns nothing. A Wilson request (func 3) returns the product,
// started from the identity register and multiplied on the right, around a
// len_first x len_second rectangle; a Polyakov request (func 4) returns the
// product of the time links around the periodic time direction. A bad site
// or direction returns loop_value 0 with the tuser flag set, at once. A good
// request first splits the site into coordinates with a shared restoring
// divider, one division per dimension in use. The walk then uses the one
// read port of each store under a small sequencer: a forward link passes
// S_SEG, S_LINK, S_MUL and S_UPD; a backward link also passes S_ADV and
// an S_INV inverse lookup. Segment ends are checked in S_SEG, and S_OUT
// hands the result to the output register. After any configuration write
// no new item is taken until the geometry multipliers have settled. Stores
// are not cleared by reset: reading an entry never written gives garbage.
module gauge_loop_product_walker_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Fields from bit 0: func[2:0], site[14:3], dir_first[16:15],
	// dir_second[18:17], len_first[24:19], len_second[30:25],
	// elem_left[38:31], elem_right[46:39], elem_value[54:47], zero pad.
	input  wire logic [glpw_pkg::IN_W-1:0]      s_axis_tdata,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: loop_value[7:0].
	output logic      [7:0]                     m_axis_tdata,
	// Fields from bit 0: bad_request[0].
	output logic                                m_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic                           cfg_we,
	input  wire logic [glpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [glpw_pkg::CFG_W-1:0]     cfg_data
);
	import glpw_pkg::*;

	// Input field unpacking.
	logic [2:0]        in_func;
	logic [SITE_W-1:0] in_site;
	logic [DIR_W-1:0]  in_d1, in_d2;
	logic [LEN_W-1:0]  in_n1, in_n2;
	logic [ELEM_W-1:0] in_el, in_er, in_ev;

	assign in_func = s_axis_tdata[2:0];
	assign in_site = s_axis_tdata[14:3];
	assign in_d1   = s_axis_tdata[16:15];
	assign in_d2   = s_axis_tdata[18:17];
	assign in_n1   = s_axis_tdata[24:19];
	assign in_n2   = s_axis_tdata[30:25];
	assign in_el   = s_axis_tdata[38:31];
	assign in_er   = s_axis_tdata[46:39];
	assign in_ev   = s_axis_tdata[54:47];

	geom_t geom;

	glpw_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	state_t state_q, state_d;

	// Request registers.
	logic              poly_q;
	logic [DIR_W-1:0]  d1_q, d2_q;
	logic [LEN_W-1:0]  n1_q, n2_q;
	logic [1:0]        seg_q;
	logic [EXT_W-1:0]  cnt_q;
	logic [DIR_W-1:0]  dcnt_q;
	logic [SITE_W-1:0] quo_q;
	logic [MAX_DIMS-1:0][COORD_W-1:0] coord_q;
	logic [STRIDE_W-1:0] pos_q;
	logic [ELEM_W-1:0] g_q;
	logic              bad_q;

	// Output register.
	logic              out_valid_q;
	logic [ELEM_W-1:0] out_value_q;
	logic              out_bad_q;

	logic accept;
	logic site_ok, d1_ok, d2_ok, req_bad;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign site_ok = STRIDE_W'(in_site) < geom.stride[geom.dims];
	assign d1_ok   = 3'(in_d1) < geom.dims;
	assign d2_ok   = 3'(in_d2) < geom.dims;
	assign req_bad = (func_t'(in_func) == F_POLY) ? !site_ok : !(site_ok && d1_ok && d2_ok);

	// Segment control: forward first, forward second, back first, back second.
	logic             bwd;
	logic [DIR_W-1:0] dir;
	logic [EXT_W-1:0] seg_len;
	logic             seg_done, last_seg;

	assign bwd      = seg_q[1];
	assign dir      = poly_q ? '0 : (seg_q[0] ? d2_q : d1_q);
	assign seg_len  = poly_q ? geom.ext_time : EXT_W'(seg_q[0] ? n2_q : n1_q);
	assign seg_done = cnt_q == seg_len;
	assign last_seg = poly_q ? 1'b1 : (seg_q == 2'd3);

	// Neighbour step along the current direction, with periodic wrap.
	logic [EXT_W-1:0]    ext_d;
	logic [STRIDE_W-1:0] st_d, wrap_d;
	logic [2:0]          dir_nx;
	logic [COORD_W-1:0]  c_d, c_nx;
	logic [STRIDE_W-1:0] pos_nx;

	assign dir_nx = 3'(dir) + 3'd1;
	assign ext_d  = (dir == '0) ? geom.ext_time : geom.ext_space;
	assign st_d   = geom.stride[dir];
	assign wrap_d = geom.stride[dir_nx] - st_d;
	assign c_d    = coord_q[dir];

	always_comb begin
		if (!bwd) begin
			if (EXT_W'(c_d) + EXT_W'(1) == ext_d) begin
				c_nx   = '0;
				pos_nx = pos_q - wrap_d;
			end else begin
				c_nx   = c_d + 1'b1;
				pos_nx = pos_q + st_d;
			end
		end else begin
			if (c_d == '0) begin
				c_nx   = COORD_W'(ext_d - EXT_W'(1));
				pos_nx = pos_q + wrap_d;
			end else begin
				c_nx   = c_d - 1'b1;
				pos_nx = pos_q - st_d;
			end
		end
	end

	// Divider for the coordinate split.
	logic              div_start, div_done;
	logic [SITE_W-1:0] div_quo;
	logic [COORD_W-1:0] div_rem;

	glpw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (quo_q),
		.divisor   ((dcnt_q == '0) ? geom.ext_time : geom.ext_space),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Stores.
	logic              link_we, prod_we, inv_we;
	logic              link_re, prod_re, inv_re;
	logic [ELEM_W-1:0] link_rd, prod_rd, inv_rd;
	logic [ELEM_W-1:0] mul_x;

	assign link_we = accept && func_t'(in_func) == F_WR_LINK && site_ok && d1_ok;
	assign prod_we = accept && func_t'(in_func) == F_WR_PROD;
	assign inv_we  = accept && func_t'(in_func) == F_WR_INV;
	assign mul_x   = bwd ? inv_rd : link_rd;

	glpw_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SITES * MAX_DIMS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr ({in_site, in_d1}),
		.wdata (in_ev),
		.re    (link_re),
		.raddr ({pos_q[SITE_W-1:0], dir}),
		.rdata (link_rd)
	);

	glpw_ram #(.WIDTH(ELEM_W), .DEPTH(GROUP_ELEMENTS * GROUP_ELEMENTS)) u_prod_ram (
		.clk   (clk),
		.we    (prod_we),
		.waddr ({in_el, in_er}),
		.wdata (in_ev),
		.re    (prod_re),
		.raddr ({g_q, mul_x}),
		.rdata (prod_rd)
	);

	glpw_ram #(.WIDTH(ELEM_W), .DEPTH(GROUP_ELEMENTS)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (in_el),
		.wdata (in_ev),
		.re    (inv_re),
		.raddr (link_rd),
		.rdata (inv_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (func_t'(in_func) == F_WILSON || func_t'(in_func) == F_POLY)) begin
					state_d = req_bad ? S_OUT : S_DIV_START;
				end
			end
			S_DIV_START: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = (3'(dcnt_q) + 3'd1 == geom.dims) ? S_SEG : S_DIV_START;
				end
			end
			S_SEG: begin
				if (seg_done) begin
					state_d = last_seg ? S_OUT : S_SEG;
				end else begin
					state_d = bwd ? S_ADV : S_LINK;
				end
			end
			S_ADV:  state_d = S_LINK;
			S_LINK: state_d = bwd ? S_INV : S_MUL;
			S_INV:  state_d = S_MUL;
			S_MUL:  state_d = S_UPD;
			S_UPD:  state_d = S_SEG;
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		link_re       = 1'b0;
		inv_re        = 1'b0;
		prod_re       = 1'b0;
		case (state_q)
			S_IDLE:      s_axis_tready = geom.settled;
			S_DIV_START: div_start = 1'b1;
			S_LINK:      link_re = 1'b1;
			S_INV:       inv_re = 1'b1;
			S_MUL:       prod_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				poly_q <= func_t'(in_func) == F_POLY;
				d1_q   <= in_d1;
				d2_q   <= in_d2;
				n1_q   <= in_n1;
				n2_q   <= in_n2;
				seg_q  <= '0;
				cnt_q  <= '0;
				dcnt_q <= '0;
				quo_q  <= in_site;
				pos_q  <= STRIDE_W'(in_site);
				g_q    <= req_bad ? '0 : geom.identity;
				bad_q  <= req_bad;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					coord_q[dcnt_q] <= div_rem;
					quo_q           <= div_quo;
					dcnt_q          <= dcnt_q + 1'b1;
				end
			end
			S_SEG: begin
				if (seg_done && !last_seg) begin
					seg_q <= seg_q + 1'b1;
					cnt_q <= '0;
				end
			end
			S_ADV: begin
				coord_q[dir] <= c_nx;
				pos_q        <= pos_nx;
			end
			S_UPD: begin
				g_q   <= prod_rd;
				cnt_q <= cnt_q + 1'b1;
				if (!bwd) begin
					coord_q[dir] <= c_nx;
					pos_q        <= pos_nx;
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_value_q <= g_q;
					out_bad_q   <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_bad_q;

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE)
		else $error("input taken outside idle");
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("flagged result carries a nonzero value");
	a_inv_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INV |-> $past(state_q) == S_LINK && bwd)
		else $error("inverse lookup without a backward link read");
	a_upd_to_seg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |=> state_q == S_SEG)
		else $error("product update not followed by segment check");
`endif
endmodule
`default_nettype wire
